// File: design/frt_pkg.sv
// Package: shared types and codes for the fragment reassembly tracker.
`default_nettype none
package frt_pkg;

    localparam int REQ_W = 2;
    localparam logic [1:0] REQ_FRAG  = 2'd0;
    localparam logic [1:0] REQ_STALE = 2'd1;
    localparam logic [1:0] REQ_EXPIRY = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_AGAIN   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] src_node;
        logic [63:0] msg_key;
        logic [7:0]  frag_pos;
        logic [7:0]  frag_total;
        logic [15:0] msg_bytes;
        logic [15:0] frag_bytes;
        logic [63:0] expiry_time;
        logic [63:0] now_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        passthrough;
        logic [3:0]  slot_index;
        logic        payload_write;
        logic [12:0] write_offset;
        logic        message_done;
        logic [12:0] assembled_length;
        logic [3:0]  freed_count;
    } rsp_t;

endpackage
`default_nettype wire

// File: design/frt_if.sv
// Interfaces: valid/ready channels for request, response and configuration items.
`default_nettype none
interface frt_req_if
    import frt_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frt_rsp_if
    import frt_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frt_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/fragment_reassembly_tracker.sv
// Top level: reassembly slot table with a sequencer that visits one slot a cycle.
//
// Usage: req carries fragment or sweep items, rsp returns exactly one result
// item per request, cfg writes the 64-bit stale threshold; it is for the
// user to write it only while idle, the block has no check for this.
// A request is taken in IDLE; for a fragment or sweep item a shared
// compare unit then scans the slots one per cycle, and the UPDATE state
// updates the chosen slot and loads the result into the output register.
// Passthrough, invalid limit checks and unknown types skip the scan and
// have their result the next cycle. The next item is accepted only once
// the result has been taken and the sequencer is back in IDLE. A stalled
// receiver holds the block with the result kept stable. Reset clears
// every slot's active bit, the control state and the threshold; the other
// slot fields are not reset, as a slot is only read while it is active.
`default_nettype none
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int MAX_FRAGMENTS = 16,
    parameter int MAX_MESSAGE_BYTES = 4096,
    parameter int FRAGMENT_BYTES = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    frt_req_if.sink   req,
    frt_rsp_if.source rsp,
    frt_cfg_if.sink   cfg
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] NONE = CW'(SLOT_COUNT);
    localparam logic [CW-1:0] HALF = CW'(SLOT_COUNT / 2);
    localparam int MW = MAX_FRAGMENTS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_COUNT-1:0] act_reg;
    logic [15:0]    src_reg [SLOT_COUNT];
    logic [63:0]    msg_reg [SLOT_COUNT];
    logic [MW-1:0]  mask_reg [SLOT_COUNT];
    logic [7:0]     exp_reg [SLOT_COUNT];
    logic [15:0]    tot_reg [SLOT_COUNT];
    logic [16:0]    rcv_reg [SLOT_COUNT];
    logic [63:0]    expiry_reg [SLOT_COUNT];
    logic [63:0]    opened_reg [SLOT_COUNT];
    logic [63:0]    thr_reg;

    req_t           cur_reg;
    logic [SW-1:0]  idx_reg;
    logic [CW-1:0]  hit_reg, free_reg, cnt_reg, freed_reg;
    logic [SLOT_COUNT-1:0] kill_reg;
    rsp_t           out_reg;
    logic           out_valid_reg;

    // shared unit: compare the scanned slot against the current item
    logic        s_act, s_srcm, s_keym, s_stale, s_expd;
    logic [63:0] age;
    always_comb
    begin
        s_act  = act_reg[idx_reg];
        s_srcm = s_act && (src_reg[idx_reg] == cur_reg.src_node);
        s_keym = s_srcm && (msg_reg[idx_reg] == cur_reg.msg_key);
        age    = cur_reg.now_time - opened_reg[idx_reg];
        s_stale = s_act && (cur_reg.now_time >= opened_reg[idx_reg]) && (age >= thr_reg)
                  && (thr_reg != 64'd0);
        s_expd = s_act && (expiry_reg[idx_reg] != 64'd0)
                 && (expiry_reg[idx_reg] <= cur_reg.now_time);
    end

    // limit checks on the incoming item
    logic        bad_lim;
    logic [7:0]  fc1;
    always_comb
    begin
        fc1 = (req.data.frag_total == 8'd0) ? 8'd1 : req.data.frag_total;
        bad_lim = (req.data.src_node == 16'd0) || (req.data.frag_pos >= fc1)
                  || (32'(req.data.frag_total) > 32'(MAX_FRAGMENTS))
                  || (32'(req.data.msg_bytes) > 32'(MAX_MESSAGE_BYTES));
    end

    // slot update arithmetic for the chosen slot
    logic [CW-1:0]  s_sel;
    logic [SW-1:0]  sl;
    logic           opening, tab_full;
    logic [MW-1:0]  bit_v, mask_old, mask_new, full_v;
    logic [7:0]     exp_v;
    logic [15:0]    tot_v;
    logic [16:0]    rcv_old, rcv_new;
    logic [31:0]    off, plen;
    logic           dup, mism, overrun, done_all, wr;
    always_comb
    begin
        opening  = (hit_reg == NONE);
        tab_full = opening && (cnt_reg >= HALF || free_reg == NONE);
        s_sel    = opening ? free_reg : hit_reg;
        sl       = s_sel[SW-1:0];
        bit_v    = MW'(1) << cur_reg.frag_pos[$clog2(MW)-1:0];
        mask_old = opening ? '0 : mask_reg[sl];
        exp_v    = opening ? cur_reg.frag_total : exp_reg[sl];
        tot_v    = opening ? cur_reg.msg_bytes : tot_reg[sl];
        rcv_old  = opening ? 17'd0 : rcv_reg[sl];
        mism     = !opening && ((cur_reg.frag_total != exp_reg[sl])
                   || (cur_reg.msg_bytes != tot_reg[sl]));
        dup      = (mask_old & bit_v) != '0;
        off      = 32'(cur_reg.frag_pos) * 32'(FRAGMENT_BYTES);
        plen     = 32'(cur_reg.frag_bytes);
        overrun  = (off > 32'(MAX_MESSAGE_BYTES))
                   || ((plen != 32'd0) && (plen > 32'(MAX_MESSAGE_BYTES) - off))
                   || (plen > 32'(MAX_MESSAGE_BYTES) - 32'(rcv_old));
        rcv_new  = rcv_old + 17'(cur_reg.frag_bytes);
        mask_new = mask_old | bit_v;
        full_v   = (MW'(1) << exp_v[$clog2(MW):0]) - MW'(1);
        if (32'(exp_v) >= 32'(MW))
        begin
            full_v = '1;
        end
        done_all = (mask_new & full_v) == full_v;
        wr       = (plen != 32'd0);
    end

    // result items: one for items that skip the scan, one after the update
    rsp_t quick_v, res_v;
    always_comb
    begin
        quick_v = '0;
        quick_v.slot_index = 4'(NONE);
        if (req.data.req_type == REQ_FRAG && !bad_lim)
        begin
            quick_v.status = ST_OK;
            quick_v.passthrough = 1'b1;
        end
        else
        begin
            quick_v.status = ST_INVALID;
        end

        res_v = '0;
        res_v.slot_index = 4'(NONE);
        if (cur_reg.req_type != REQ_FRAG)
        begin
            res_v.status = ST_OK;
            res_v.freed_count = 4'(freed_reg);
        end
        else if (tab_full)
        begin
            res_v.status = ST_FULL;
        end
        else
        begin
            res_v.slot_index = 4'(s_sel);
            if (mism)
            begin
                res_v.status = ST_INVALID;
            end
            else if (dup)
            begin
                res_v.status = ST_AGAIN;
            end
            else if (overrun)
            begin
                res_v.status = ST_INVALID;
            end
            else
            begin
                res_v.payload_write = wr;
                res_v.write_offset = wr ? 13'(off) : 13'd0;
                if (!done_all)
                begin
                    res_v.status = ST_AGAIN;
                end
                else if (rcv_new != 17'(tot_v))
                begin
                    res_v.status = ST_INVALID;
                end
                else
                begin
                    res_v.status = ST_OK;
                    res_v.message_done = 1'b1;
                    res_v.assembled_length = 13'(tot_v);
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && !out_valid_reg)
                begin
                    if (req.data.req_type == REQ_STALE || req.data.req_type == REQ_EXPIRY
                        || (req.data.req_type == REQ_FRAG && !bad_lim
                            && req.data.frag_total > 8'd1))
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:   if (32'(idx_reg) == SLOT_COUNT - 1) state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:    if (!out_valid_reg) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // control, scan results and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= NONE;
            free_reg      <= NONE;
            cnt_reg       <= '0;
            freed_reg     <= '0;
            kill_reg      <= '0;
            thr_reg       <= '0;
            act_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
            if (rsp.ready && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg   <= '0;
                    hit_reg   <= NONE;
                    free_reg  <= NONE;
                    cnt_reg   <= '0;
                    freed_reg <= '0;
                    kill_reg  <= '0;
                    if (req.valid && req.ready && state_next == S_IDLE)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= quick_v;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + SW'(1);
                    if (s_keym && hit_reg == NONE) hit_reg <= CW'(idx_reg);
                    if (!s_act && free_reg == NONE) free_reg <= CW'(idx_reg);
                    if (s_srcm) cnt_reg <= cnt_reg + CW'(1);
                    if ((cur_reg.req_type == REQ_STALE && s_stale)
                        || (cur_reg.req_type == REQ_EXPIRY && s_expd))
                    begin
                        kill_reg[idx_reg] <= 1'b1;
                        freed_reg <= freed_reg + CW'(1);
                    end
                end
                S_UPDATE:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg <= res_v;
                    if (cur_reg.req_type != REQ_FRAG)
                    begin
                        act_reg <= act_reg & ~kill_reg;
                    end
                    else if (!tab_full && !mism)
                    begin
                        // keep the slot open unless it overran or completed
                        act_reg[sl] <= dup || (!overrun && !done_all);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // capture item and update slot payload fields
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cur_reg <= req.data;
        end
        if (state_reg == S_UPDATE)
        begin
            if (cur_reg.req_type != REQ_FRAG)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (kill_reg[i])
                    begin
                        mask_reg[i] <= '0;
                        exp_reg[i]  <= '0;
                        rcv_reg[i]  <= '0;
                        if (cur_reg.req_type == REQ_STALE) opened_reg[i] <= '0;
                    end
                end
            end
            else if (!tab_full && !mism)
            begin
                if (opening)
                begin
                    src_reg[sl]    <= cur_reg.src_node;
                    msg_reg[sl]    <= cur_reg.msg_key;
                    tot_reg[sl]    <= cur_reg.msg_bytes;
                    expiry_reg[sl] <= cur_reg.expiry_time;
                    opened_reg[sl] <= cur_reg.now_time;
                end
                if (!dup)
                begin
                    if (overrun || done_all)
                    begin
                        mask_reg[sl] <= '0;
                        exp_reg[sl]  <= '0;
                        rcv_reg[sl]  <= '0;
                    end
                    else
                    begin
                        mask_reg[sl] <= mask_new;
                        rcv_reg[sl]  <= rcv_new;
                        if (opening) exp_reg[sl] <= cur_reg.frag_total;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire
